@@ src/sfr_pkg.sv @@
// shared types and constants for the serial frame receiver
// no dependencies

package sfr_pkg;

  localparam logic [7:0] HDR_FIRST      = 8'hFE;
  localparam logic [7:0] HDR_SECOND     = 8'h68;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd128;
  localparam logic [7:0] HDR_SUM        = HDR_FIRST + HDR_SECOND;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] source_address;
    logic [7:0] dest_address;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       checksum_ok;
  } result_t;

endpackage

@@ src/serial_frame_receiver.sv @@
// serial frame receiver top level: config register, parser, result buffer
// depends on sfr_pkg, sfr_parser, sfr_skid

// Takes one received byte per request: the parser state and running checksum
// update in the cycle a byte is accepted, and any result lands in a two-entry
// output buffer, so a byte can be accepted every cycle while the buffer has
// room. Results are registered in the output buffer, behind any result still
// waiting there. Payload bytes give kind 0 results; the checksum byte
// gives a kind 1 result with checksum_ok. max_payload resets to 128 and may be
// written at any time through the cfg channel (always ready); it is used at the
// next length byte.

module serial_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_payload,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_source_address,
  output logic [7:0] out_dest_address,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_length,
  output logic       out_checksum_ok
);
  import sfr_pkg::*;

  logic [7:0] max_payload_r;
  logic       accept;
  logic       res_valid;
  logic       full;
  result_t    res;
  result_t    out_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~full;
  assign accept    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  sfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_payload_index  = out_data.payload_index;
  assign out_source_address = out_data.source_address;
  assign out_dest_address   = out_data.dest_address;
  assign out_command_code   = out_data.command_code;
  assign out_payload_length = out_data.payload_length;
  assign out_checksum_ok    = out_data.checksum_ok;

endmodule

@@ src/sfr_parser.sv @@
// frame parser: header hunt, field capture, running checksum, result build
// depends on sfr_pkg

module sfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      max_payload,
  output logic            res_valid,
  output sfr_pkg::result_t res
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD1, PH_HEAD2, PH_GOT_FROM,
    PH_GOT_TO, PH_GOT_CMD, PH_PAYLOAD, PH_CKSUM
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] from_r, from_nxt;
  logic [7:0] to_r, to_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_add;
  logic [7:0] count_inc;
  logic       emit;

  assign sum_add   = sum_r + rx_byte;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    res       = '0;
    res.source_address = from_r;
    res.dest_address   = to_r;
    res.command_code   = cmd_r;
    res.payload_length = len_r;
    case (phase_r)
      PH_CKSUM: begin
        emit            = 1'b1;
        res.kind        = KIND_FRAME_END;
        res.checksum_ok = (sum_add == 8'd0);
        phase_nxt       = PH_IDLE;
      end
      PH_PAYLOAD: begin
        emit              = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = count_r;
        sum_nxt           = sum_add;
        count_nxt         = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CKSUM;
        end
      end
      PH_GOT_CMD: begin
        if (rx_byte <= max_payload) begin
          len_nxt   = rx_byte;
          count_nxt = 8'd0;
          sum_nxt   = sum_add;
          phase_nxt = (rx_byte == 8'd0) ? PH_CKSUM : PH_PAYLOAD;
        end
      end
      PH_GOT_TO: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_GOT_CMD;
      end
      PH_GOT_FROM: begin
        to_nxt    = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_GOT_TO;
      end
      PH_HEAD2: begin
        from_nxt  = rx_byte;
        sum_nxt   = sum_add;
        phase_nxt = PH_GOT_FROM;
      end
      PH_HEAD1: begin
        if (rx_byte == HDR_SECOND) begin
          sum_nxt   = HDR_SUM;
          phase_nxt = PH_HEAD2;
        end else if (rx_byte == HDR_FIRST) begin
          phase_nxt = PH_HEAD1;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = (rx_byte == HDR_FIRST) ? PH_HEAD1 : PH_IDLE;
      end
    endcase
  end

  assign res_valid = accept & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      from_r  <= 8'd0;
      to_r    <= 8'd0;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      count_r <= 8'd0;
      sum_r   <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      from_r  <= from_nxt;
      to_r    <= to_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

@@ src/sfr_skid.sv @@
// two-entry result buffer between the parser and the output channel
// depends on sfr_pkg

module sfr_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfr_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::result_t out_data
);
  import sfr_pkg::*;

  result_t    ent0_r, ent0_nxt;
  result_t    ent1_r, ent1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_ready & (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent0_r;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    cnt_nxt  = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          ent0_nxt = push_data;
        end else begin
          ent1_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        ent0_nxt = ent1_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          ent0_nxt = push_data;
        end else begin
          ent0_nxt = ent1_r;
          ent1_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule

@@ src/sfr_checker.sv @@
// port-level checks for the serial frame receiver, bound to the top level
// depends on serial_frame_receiver ports only

module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic [7:0] out_payload_length,
  input logic       out_checksum_ok
);

  // a stalled request stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_checksum_ok && (out_payload_index < out_payload_length))
    else $error("payload result with bad index or verdict");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> (out_payload_byte == 8'd0) && (out_payload_index == 8'd0))
    else $error("frame end result with nonzero data");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_payload_byte   (out_payload_byte),
  .out_payload_index  (out_payload_index),
  .out_payload_length (out_payload_length),
  .out_checksum_ok    (out_checksum_ok)
);
